/* rtl/bqpd_pkg.sv */
`timescale 1ns / 1ps

package bqpd_pkg;

    // field widths
    localparam int unsigned TimeWidth    = 32;
    localparam int unsigned SpacingWidth = 16;
    localparam int unsigned WindowWidth  = 16;
    localparam int unsigned CountWidth   = 8;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned CfgIdxWidth  = 2;

    // register reset values
    localparam logic [SpacingWidth-1:0] MinSpacingUsReset  = 16'd300;
    localparam logic [WindowWidth-1:0]  BurstWindowMsReset = 16'd60;
    localparam logic [CountWidth-1:0]   BurstThresholdReset = 8'd80;

    // configuration register indexes
    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_MIN_SPACING_US  = 2'd0,
        CFG_BURST_WINDOW_MS = 2'd1,
        CFG_BURST_THRESHOLD = 2'd2
    } bqpd_cfg_idx_t;

    // item kinds
    typedef enum logic {
        OP_EDGE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } bqpd_op_t;

endpackage

/* rtl/bqpd_if.sv */
`timescale 1ns / 1ps

// edge or timeout item channel
interface bqpd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 op;
    logic [bqpd_pkg::TimeWidth-1:0]       time_us;
    logic [bqpd_pkg::TimeWidth-1:0]       time_ms;

    modport source (output valid, output op, output time_us, output time_ms, input ready);
    modport sink   (input valid, input op, input time_us, input time_ms, output ready);
endinterface

// result channel
interface bqpd_out_if;
    logic valid;
    logic ready;
    logic restart_hold;
    logic detected;
    logic cleared;
    logic present_now;

    modport source (output valid, output restart_hold, output detected, output cleared,
                    output present_now, input ready);
    modport sink   (input valid, input restart_hold, input detected, input cleared,
                    input present_now, output ready);
endinterface

/* rtl/burst_qualified_presence_detector.sv */
`timescale 1ns / 1ps

// channel    dir   payload                              handshake
// items      in    op, time_us[31:0], time_ms[31:0]     valid / ready
// results    out   restart_hold, detected, cleared,     valid / ready
//                  present_now
// config     in    cfg_index[1:0], cfg_data[15:0]       cfg_we, no ready
//
// A transfer lands in the input register; from there the detector state is
// updated and the result register loaded when the result register is free.
// One item per cycle is sustained while results drain.
// Reset clears presence, baseline, burst start and count, and loads the
// register defaults. A stalled result holds the input register, which then
// takes a new transfer only as the result register frees up.

module burst_qualified_presence_detector
(
    input  logic                                clk,
    input  logic                                rst_n,
    bqpd_in_if.sink                             items,
    bqpd_out_if.source                          results,
    input  logic                                cfg_we,
    input  logic [bqpd_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [bqpd_pkg::CfgDataWidth-1:0]   cfg_data
);

    localparam int unsigned TW = bqpd_pkg::TimeWidth;
    localparam int unsigned CW = bqpd_pkg::CountWidth;

    // configuration registers
    logic [bqpd_pkg::SpacingWidth-1:0] min_spacing_us_reg;
    logic [bqpd_pkg::WindowWidth-1:0]  burst_window_ms_reg;
    logic [CW-1:0]                     burst_threshold_reg;

    // detector state
    logic          presence_reg,         presence_next;
    logic [TW-1:0] last_accepted_us_reg, last_accepted_us_next;
    logic [TW-1:0] burst_start_ms_reg,   burst_start_ms_next;
    logic [CW-1:0] burst_count_reg,      burst_count_next;

    // input register
    logic          s1_valid_reg;
    logic          s1_op_reg;
    logic [TW-1:0] s1_time_us_reg;
    logic [TW-1:0] s1_time_ms_reg;

    // result register
    logic out_valid_reg;
    logic restart_reg, restart_next;
    logic detected_reg, detected_next;
    logic cleared_reg, cleared_next;
    logic present_reg;

    logic          advance;
    logic          in_xfer;
    logic          is_timeout;
    logic          us_backward;
    logic [TW-1:0] us_gap;
    logic [TW-1:0] ms_gap;
    logic          edge_ok;
    logic          new_burst;
    logic [CW-1:0] count_upd;
    logic          confirm;

    // handshake
    assign advance       = s1_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready   = !s1_valid_reg || advance;
    assign in_xfer       = items.valid && items.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_spacing_us_reg  <= bqpd_pkg::MinSpacingUsReset;
            burst_window_ms_reg <= bqpd_pkg::BurstWindowMsReset;
            burst_threshold_reg <= bqpd_pkg::BurstThresholdReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bqpd_pkg::CFG_MIN_SPACING_US:  min_spacing_us_reg  <= cfg_data;
                bqpd_pkg::CFG_BURST_WINDOW_MS: burst_window_ms_reg <= cfg_data;
                bqpd_pkg::CFG_BURST_THRESHOLD: burst_threshold_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            s1_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg      <= items.op;
            s1_time_us_reg <= items.time_us;
            s1_time_ms_reg <= items.time_ms;
        end
    end

    // edge qualification and burst counting
    always_comb
    begin
        is_timeout  = (s1_op_reg == bqpd_pkg::OP_TIMEOUT);
        us_backward = s1_time_us_reg < last_accepted_us_reg;
        us_gap      = s1_time_us_reg - last_accepted_us_reg;
        ms_gap      = s1_time_ms_reg - burst_start_ms_reg;
        edge_ok     = !is_timeout && !us_backward
                      && (us_gap >= {{(TW-bqpd_pkg::SpacingWidth){1'b0}}, min_spacing_us_reg});
        new_burst   = ms_gap > {{(TW-bqpd_pkg::WindowWidth){1'b0}}, burst_window_ms_reg};

        if (new_burst)
            count_upd = {{(CW-1){1'b0}}, 1'b1};
        else if (burst_count_reg < burst_threshold_reg)
            count_upd = burst_count_reg + {{(CW-1){1'b0}}, 1'b1};
        else
            count_upd = burst_count_reg;

        confirm = edge_ok && (count_upd >= burst_threshold_reg);

        presence_next         = presence_reg;
        last_accepted_us_next = last_accepted_us_reg;
        burst_start_ms_next   = burst_start_ms_reg;
        burst_count_next      = burst_count_reg;
        restart_next          = 1'b0;
        detected_next         = 1'b0;
        cleared_next          = 1'b0;

        if (is_timeout)
        begin
            presence_next = 1'b0;
            cleared_next  = presence_reg;
        end
        else if (us_backward)
        begin
            last_accepted_us_next = s1_time_us_reg;
        end
        else if (edge_ok)
        begin
            last_accepted_us_next = s1_time_us_reg;
            burst_count_next      = count_upd;
            if (new_burst)
                burst_start_ms_next = s1_time_ms_reg;
            if (confirm)
            begin
                restart_next  = 1'b1;
                presence_next = 1'b1;
                detected_next = !presence_reg;
            end
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_reg         <= 1'b0;
            last_accepted_us_reg <= '0;
            burst_start_ms_reg   <= '0;
            burst_count_reg      <= '0;
        end
        else if (advance)
        begin
            presence_reg         <= presence_next;
            last_accepted_us_reg <= last_accepted_us_next;
            burst_start_ms_reg   <= burst_start_ms_next;
            burst_count_reg      <= burst_count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            restart_reg  <= restart_next;
            detected_reg <= detected_next;
            cleared_reg  <= cleared_next;
            present_reg  <= presence_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.restart_hold = restart_reg;
    assign results.detected     = detected_reg;
    assign results.cleared      = cleared_reg;
    assign results.present_now  = present_reg;

    // a confirmed edge leaves presence set
    a_confirm_sets_presence: assert property (@(posedge clk) disable iff (!rst_n)
        advance && restart_next |=> presence_reg && results.present_now)
        else $error("confirmed edge did not set presence");

    // a timeout clears presence and leaves the burst count alone
    a_timeout_effect: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_timeout |=> !presence_reg && $stable(burst_count_reg))
        else $error("timeout did not clear presence cleanly");

    // a held input register never takes a new transfer
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |-> !items.ready)
        else $error("input register overrun");

endmodule

/* bench/burst_qualified_presence_detector_tb.sv */
`timescale 1ns / 1ps

module burst_qualified_presence_detector_tb;

    localparam int unsigned ClkPeriod    = 10;
    localparam int unsigned ResetCycles  = 10;
    localparam int unsigned HoldCycles   = 80;
    localparam int unsigned DrainCycles  = 4;
    localparam int unsigned StallLimit   = 1000;
    localparam int unsigned TimeWidth    = bqpd_pkg::TimeWidth;
    localparam int unsigned SpacingWidth = bqpd_pkg::SpacingWidth;
    localparam int unsigned WindowWidth  = bqpd_pkg::WindowWidth;
    localparam int unsigned CountWidth   = bqpd_pkg::CountWidth;
    localparam int unsigned CfgDataWidth = bqpd_pkg::CfgDataWidth;

    typedef struct packed {
        logic restart_hold;
        logic detected;
        logic cleared;
        logic present_now;
    } presence_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    bqpd_pkg::bqpd_cfg_idx_t   cfg_index;
    logic [CfgDataWidth-1:0]   cfg_data;

    bqpd_in_if  items_ch ();
    bqpd_out_if results_ch ();

    // detector state as the bench tracks it
    logic                      presence_q;
    logic [TimeWidth-1:0]      last_us_q;
    logic [TimeWidth-1:0]      burst_start_q;
    logic [CountWidth-1:0]     burst_count_q;
    logic [SpacingWidth-1:0]   spacing_cfg;
    logic [WindowWidth-1:0]    window_cfg;
    logic [CountWidth-1:0]     threshold_cfg;

    presence_result_t          expected_results[$];

    // stimulus cursors and idling controls
    logic [TimeWidth-1:0]      us_cursor;
    logic [TimeWidth-1:0]      ms_cursor;
    bit                        src_idle_on;
    bit                        sink_idle_on;
    bit                        sink_hold_req;
    int unsigned               error_count;
    int unsigned               stall_cycles;

    burst_qualified_presence_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    // next presence result for one item, updates the tracked state
    function automatic presence_result_t predict_presence(input bqpd_pkg::bqpd_op_t op,
                                                          input logic [TimeWidth-1:0] t_us,
                                                          input logic [TimeWidth-1:0] t_ms);
        presence_result_t r;
        logic [TimeWidth-1:0] ms_gap;
        r = '0;
        if (op == bqpd_pkg::OP_TIMEOUT)
        begin
            if (presence_q)
            begin
                presence_q = 1'b0;
                r.cleared  = 1'b1;
            end
        end
        else if (t_us < last_us_q)
        begin
            last_us_q = t_us;
        end
        else if (t_us - last_us_q >= TimeWidth'(spacing_cfg))
        begin
            last_us_q = t_us;
            ms_gap    = t_ms - burst_start_q;
            if (ms_gap > TimeWidth'(window_cfg))
            begin
                burst_start_q = t_ms;
                burst_count_q = 8'd1;
            end
            else if (burst_count_q < threshold_cfg)
            begin
                burst_count_q = burst_count_q + 8'd1;
            end
            if (burst_count_q >= threshold_cfg)
            begin
                r.restart_hold = 1'b1;
                if (!presence_q)
                begin
                    presence_q = 1'b1;
                    r.detected = 1'b1;
                end
            end
        end
        r.present_now = presence_q;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_results
        presence_result_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no expected result pending");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (results_ch.restart_hold !== want.restart_hold)
                begin
                    $error("restart_hold expected %0b got %0b", want.restart_hold,
                           results_ch.restart_hold);
                    error_count++;
                end
                if (results_ch.detected !== want.detected)
                begin
                    $error("detected expected %0b got %0b", want.detected, results_ch.detected);
                    error_count++;
                end
                if (results_ch.cleared !== want.cleared)
                begin
                    $error("cleared expected %0b got %0b", want.cleared, results_ch.cleared);
                    error_count++;
                end
                if (results_ch.present_now !== want.present_now)
                begin
                    $error("present_now expected %0b got %0b", want.present_now,
                           results_ch.present_now);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result ready: random stall bursts, one long hold on request
    initial
    begin
        int unsigned gap;
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                results_ch.ready <= 1'b0;
                sink_hold_req = 1'b0;
                repeat (HoldCycles - 1) @(negedge clk);
            end
            else if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 7);
                results_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                results_ch.ready <= 1'b1;
            end
        end
    end

    // one item transfer, valid stays high until the next call or a drain
    task automatic send_item(input bqpd_pkg::bqpd_op_t op, input logic [TimeWidth-1:0] t_us,
                             input logic [TimeWidth-1:0] t_ms);
        int unsigned gap;
        begin
            @(negedge clk);
            if (src_idle_on && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 7);
                items_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            items_ch.valid   <= 1'b1;
            items_ch.op      <= op;
            items_ch.time_us <= t_us;
            items_ch.time_ms <= t_ms;
            do @(posedge clk); while (!items_ch.ready);
            expected_results.push_back(predict_presence(op, t_us, t_ms));
        end
    endtask

    // sender pauses until every result is back
    task automatic wait_results_drained();
        begin
            @(negedge clk);
            items_ch.valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge clk);
            repeat (DrainCycles) @(posedge clk);
        end
    endtask

    task automatic write_reg(input bqpd_pkg::bqpd_cfg_idx_t idx,
                             input logic [CfgDataWidth-1:0] data);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            case (idx)
                bqpd_pkg::CFG_MIN_SPACING_US:  spacing_cfg   = data;
                bqpd_pkg::CFG_BURST_WINDOW_MS: window_cfg    = data;
                bqpd_pkg::CFG_BURST_THRESHOLD: threshold_cfg = data[CountWidth-1:0];
                default: ;
            endcase
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic set_detector_config(input logic [SpacingWidth-1:0] spacing,
                                       input logic [WindowWidth-1:0] window,
                                       input logic [CountWidth-1:0] threshold);
        logic [7:0] junk;
        begin
            junk = 8'($urandom_range(0, 255));
            write_reg(bqpd_pkg::CFG_MIN_SPACING_US, spacing);
            write_reg(bqpd_pkg::CFG_BURST_WINDOW_MS, window);
            // upper data byte is not part of the threshold
            write_reg(bqpd_pkg::CFG_BURST_THRESHOLD, {junk, threshold});
        end
    endtask

    // mostly well-formed edge bursts, some timeouts, rebaselines and noise
    task automatic run_edge_traffic(input int unsigned count);
        int unsigned pick;
        int unsigned step_max;
        logic [TimeWidth-1:0] us_step;
        logic [TimeWidth-1:0] ms_step;
        begin
            us_cursor = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                                     : $urandom;
            ms_cursor = $urandom;
            step_max  = (threshold_cfg == 0) ? 32'(window_cfg)
                                             : 32'(window_cfg) / (32'd2 * 32'(threshold_cfg));
            repeat (count)
            begin
                pick = $urandom_range(0, 999);
                if (pick < 40)
                begin
                    send_item(bqpd_pkg::OP_TIMEOUT, $urandom, $urandom);
                end
                else if (pick < 80)
                begin
                    send_item(bqpd_pkg::OP_EDGE, us_cursor - $urandom_range(1, 5000), ms_cursor);
                end
                else if (pick < 120)
                begin
                    us_cursor = $urandom;
                    send_item(bqpd_pkg::OP_EDGE, us_cursor, ms_cursor);
                end
                else if (pick < 125)
                begin
                    us_cursor = $urandom;
                    ms_cursor = $urandom;
                    send_item(bqpd_pkg::OP_EDGE, us_cursor, ms_cursor);
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        us_step = $urandom_range(0, 32'(spacing_cfg));
                    end
                    else
                    begin
                        us_step = TimeWidth'(spacing_cfg) + $urandom_range(0, 1000);
                    end
                    if ($urandom_range(0, 32'd4 * 32'(threshold_cfg)) == 0)
                    begin
                        ms_step = TimeWidth'(window_cfg) + 32'd1 + $urandom_range(0, 100);
                    end
                    else
                    begin
                        ms_step = $urandom_range(0, step_max);
                    end
                    us_cursor = us_cursor + us_step;
                    ms_cursor = ms_cursor + ms_step;
                    send_item(bqpd_pkg::OP_EDGE, us_cursor, ms_cursor);
                end
            end
        end
    endtask

    // reset values of the registers, field extremes
    task automatic test_reset_defaults();
        begin
            send_item(bqpd_pkg::OP_EDGE, 32'd0, 32'd0);
            send_item(bqpd_pkg::OP_EDGE, 32'd300, 32'd10);
            send_item(bqpd_pkg::OP_EDGE, 32'd599, 32'd20);
            send_item(bqpd_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_item(bqpd_pkg::OP_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_item(bqpd_pkg::OP_EDGE, 32'd5, 32'd0);
            wait_results_drained();
        end
    endtask

    // threshold of zero confirms every accepted edge
    task automatic test_zero_threshold();
        begin
            set_detector_config(16'd0, 16'd0, 8'd0);
            send_item(bqpd_pkg::OP_EDGE, 32'd5, 32'd0);
            send_item(bqpd_pkg::OP_EDGE, 32'd5, 32'd0);
            send_item(bqpd_pkg::OP_EDGE, 32'h8000_0000, 32'h1234_5678);
            send_item(bqpd_pkg::OP_TIMEOUT, 32'd0, 32'd0);
            send_item(bqpd_pkg::OP_TIMEOUT, 32'd0, 32'd0);
            wait_results_drained();
        end
    endtask

    // confirm, saturation, too-close, rebaseline and millisecond wrap
    task automatic test_burst_confirm();
        begin
            set_detector_config(16'd100, 16'd10, 8'd3);
            send_item(bqpd_pkg::OP_TIMEOUT, 32'd0, 32'd0);
            send_item(bqpd_pkg::OP_EDGE, 32'd0, 32'd0);
            send_item(bqpd_pkg::OP_EDGE, 32'd1000, 32'hFFFF_FFFA);
            send_item(bqpd_pkg::OP_EDGE, 32'd1050, 32'hFFFF_FFFB);
            send_item(bqpd_pkg::OP_EDGE, 32'd1100, 32'hFFFF_FFFF);
            send_item(bqpd_pkg::OP_EDGE, 32'd1200, 32'd3);
            send_item(bqpd_pkg::OP_EDGE, 32'd1300, 32'd4);
            send_item(bqpd_pkg::OP_TIMEOUT, 32'd1300, 32'd4);
            send_item(bqpd_pkg::OP_EDGE, 32'd1400, 32'd4);
            send_item(bqpd_pkg::OP_EDGE, 32'd1500, 32'd20);
            wait_results_drained();
        end
    endtask

    // long result stall while items keep coming
    task automatic test_output_backpressure();
        bit src_idle_saved;
        begin
            src_idle_saved = src_idle_on;
            src_idle_on    = 1'b0;
            sink_hold_req  = 1'b1;
            run_edge_traffic(24);
            wait_results_drained();
            src_idle_on = src_idle_saved;
        end
    endtask

    task automatic test_random_traffic(input logic [SpacingWidth-1:0] spacing,
                                       input logic [WindowWidth-1:0] window,
                                       input logic [CountWidth-1:0] threshold,
                                       input int unsigned count);
        begin
            set_detector_config(spacing, window, threshold);
            run_edge_traffic(count);
            wait_results_drained();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = bqpd_pkg::CFG_MIN_SPACING_US;
        cfg_data         = '0;
        items_ch.valid   = 1'b0;
        items_ch.op      = bqpd_pkg::OP_EDGE;
        items_ch.time_us = '0;
        items_ch.time_ms = '0;
        presence_q       = 1'b0;
        last_us_q        = '0;
        burst_start_q    = '0;
        burst_count_q    = '0;
        spacing_cfg      = bqpd_pkg::MinSpacingUsReset;
        window_cfg       = bqpd_pkg::BurstWindowMsReset;
        threshold_cfg    = bqpd_pkg::BurstThresholdReset;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        sink_hold_req    = 1'b0;
        error_count      = 0;
        stall_cycles     = 0;

        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_threshold();
        test_burst_confirm();
        test_random_traffic(16'd300, 16'd60, 8'd80, 250);
        test_random_traffic(16'd0, 16'd0, 8'd1, 150);
        test_random_traffic(16'hFFFF, 16'hFFFF, 8'd255, 250);
        test_output_backpressure();
        test_random_traffic(SpacingWidth'($urandom_range(0, 2000)),
                            WindowWidth'($urandom_range(0, 200)),
                            CountWidth'($urandom_range(1, 20)), 200);
        test_random_traffic(SpacingWidth'($urandom_range(0, 65535)),
                            WindowWidth'($urandom_range(0, 65535)),
                            CountWidth'($urandom_range(1, 255)), 150);

        // closing stretch with both sides streaming
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_traffic(SpacingWidth'($urandom_range(0, 1000)),
                            WindowWidth'($urandom_range(0, 100)),
                            CountWidth'($urandom_range(1, 12)), 200);

        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
